@@ rtl/bdlp_pkg.sv @@
// Shared constants and types for the button debouncer with long-press detection.
`timescale 1ns / 1ps

package bdlp_pkg;

  localparam int BUTTONS     = 3;
  localparam int COUNT_WIDTH = 16;
  localparam int FIELD_WIDTH = 3;
  localparam int LIMIT_WIDTH = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  // Width used for comparing a counter against a limit
  localparam int CMP_W     = (COUNT_WIDTH > LIMIT_WIDTH) ? COUNT_WIDTH : LIMIT_WIDTH;
  // Lanes that have a bit in the fixed-width fields
  localparam int OUT_LANES = (BUTTONS < FIELD_WIDTH) ? BUTTONS : FIELD_WIDTH;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SCAN_ENABLE       = 2'd0,
    REG_DEBOUNCE_LIMIT    = 2'd1,
    REG_LONG_PRESS_LIMIT  = 2'd2,
    REG_LONG_PRESS_ENABLE = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic                   scan_enable;
    logic [LIMIT_WIDTH-1:0] debounce_limit;
    logic [LIMIT_WIDTH-1:0] long_press_limit;
    logic                   long_press_enable;
  } cfg_t;

  // What one lane reports for the tick it is processing
  typedef struct packed {
    logic press;
    logic long_press;
    logic stable;
  } lane_result_t;

  function automatic logic [COUNT_WIDTH-1:0] count_up(input logic [COUNT_WIDTH-1:0] c);
    count_up = (c == {COUNT_WIDTH{1'b1}}) ? c : c + COUNT_WIDTH'(1);
  endfunction

  function automatic logic reached(input logic [COUNT_WIDTH-1:0] c,
                                   input logic [LIMIT_WIDTH-1:0] lim);
    reached = CMP_W'(c) >= CMP_W'(lim);
  endfunction

endpackage

@@ rtl/bdlp_lane.sv @@
// Per-button debounce and long-press core.
`timescale 1ns / 1ps

module bdlp_lane (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic                  raw,
  input  bdlp_pkg::cfg_t        cfg,
  output bdlp_pkg::lane_result_t result
);

  logic                            stable;
  logic                            stable_next;
  logic [bdlp_pkg::COUNT_WIDTH-1:0] debounce_count;
  logic [bdlp_pkg::COUNT_WIDTH-1:0] debounce_count_next;
  logic [bdlp_pkg::COUNT_WIDTH-1:0] hold_count;
  logic [bdlp_pkg::COUNT_WIDTH-1:0] hold_count_next;
  logic                            long_fired;
  logic                            long_fired_next;
  logic                            press;
  logic                            long_press;
  logic [bdlp_pkg::COUNT_WIDTH-1:0] deb_inc;
  logic [bdlp_pkg::COUNT_WIDTH-1:0] hold_inc;

  assign deb_inc  = bdlp_pkg::count_up(debounce_count);
  assign hold_inc = bdlp_pkg::count_up(hold_count);

  always_comb begin
    stable_next         = stable;
    debounce_count_next = debounce_count;
    hold_count_next     = hold_count;
    long_fired_next     = long_fired;
    press               = 1'b0;
    long_press          = 1'b0;
    if (cfg.scan_enable) begin
      if (raw != stable) begin
        debounce_count_next = deb_inc;
        if (bdlp_pkg::reached(deb_inc, cfg.debounce_limit)) begin
          stable_next         = raw;
          debounce_count_next = '0;
          if (!raw) begin
            press = 1'b1;
          end else begin
            long_fired_next = 1'b0;
            hold_count_next = '0;
          end
        end
      end else begin
        debounce_count_next = '0;
      end
      // a release clears hold state and leaves stable_next high, so the
      // hold branch below never sees a cleared count in the same tick
      if (cfg.long_press_enable && !long_fired && !stable_next) begin
        hold_count_next = hold_inc;
        if (bdlp_pkg::reached(hold_inc, cfg.long_press_limit)) begin
          hold_count_next = '0;
          long_fired_next = 1'b1;
          long_press      = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stable         <= 1'b1;
      debounce_count <= '0;
      hold_count     <= '0;
      long_fired     <= 1'b0;
    end else if (step) begin
      stable         <= stable_next;
      debounce_count <= debounce_count_next;
      hold_count     <= hold_count_next;
      long_fired     <= long_fired_next;
    end
  end

  assign result.press      = press;
  assign result.long_press = long_press;
  assign result.stable     = stable_next;

endmodule

@@ rtl/bdlp_merge.sv @@
// Gathers the lane results into the registered output transaction.
`timescale 1ns / 1ps

module bdlp_merge (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                step,
  input  bdlp_pkg::lane_result_t              lane_res [bdlp_pkg::BUTTONS],
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [bdlp_pkg::FIELD_WIDTH-1:0]    press_events,
  output logic [bdlp_pkg::FIELD_WIDTH-1:0]    long_press_events,
  output logic [bdlp_pkg::FIELD_WIDTH-1:0]    stable_levels
);

  logic [bdlp_pkg::FIELD_WIDTH-1:0] press_next;
  logic [bdlp_pkg::FIELD_WIDTH-1:0] long_next;
  logic [bdlp_pkg::FIELD_WIDTH-1:0] stable_next;

  for (genvar i = 0; i < bdlp_pkg::FIELD_WIDTH; i++) begin : g_bit
    if (i < bdlp_pkg::OUT_LANES) begin : g_lane
      assign press_next[i]  = lane_res[i].press;
      assign long_next[i]   = lane_res[i].long_press;
      assign stable_next[i] = lane_res[i].stable;
    end else begin : g_none
      assign press_next[i]  = 1'b0;
      assign long_next[i]   = 1'b0;
      assign stable_next[i] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      press_events      <= press_next;
      long_press_events <= long_next;
      stable_levels     <= stable_next;
    end
  end

endmodule

@@ rtl/button_debounce_long_press.sv @@
// Each accepted input transaction's result is registered in the output register.
// Throughput: one transaction per cycle; all button lanes update together each tick.
// The single output register is refilled in the cycle it is drained, so input stalls only
// while a result waits unaccepted. Synchronous active-high reset restores register defaults,
// sets every button released and armed with cleared counters, and empties the output.
`timescale 1ns / 1ps

module button_debounce_long_press (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [bdlp_pkg::FIELD_WIDTH-1:0]   pin_levels,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [bdlp_pkg::FIELD_WIDTH-1:0]   press_events,
  output logic [bdlp_pkg::FIELD_WIDTH-1:0]   long_press_events,
  output logic [bdlp_pkg::FIELD_WIDTH-1:0]   stable_levels,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bdlp_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [bdlp_pkg::CFG_DATA_W-1:0]    cfg_data
);

  bdlp_pkg::cfg_t         cfg;
  bdlp_pkg::lane_result_t lane_res [bdlp_pkg::BUTTONS];
  logic                   step;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign step      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scan_enable       <= 1'b0;
      cfg.debounce_limit    <= bdlp_pkg::LIMIT_WIDTH'(50);
      cfg.long_press_limit  <= bdlp_pkg::LIMIT_WIDTH'(100);
      cfg.long_press_enable <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (bdlp_pkg::cfg_reg_t'(cfg_index))
        bdlp_pkg::REG_SCAN_ENABLE:       cfg.scan_enable       <= cfg_data[0];
        bdlp_pkg::REG_DEBOUNCE_LIMIT:    cfg.debounce_limit    <= cfg_data[bdlp_pkg::LIMIT_WIDTH-1:0];
        bdlp_pkg::REG_LONG_PRESS_LIMIT:  cfg.long_press_limit  <= cfg_data[bdlp_pkg::LIMIT_WIDTH-1:0];
        bdlp_pkg::REG_LONG_PRESS_ENABLE: cfg.long_press_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < bdlp_pkg::BUTTONS; i++) begin : g_lane
    logic raw;
    // buttons with no input pin read as pressed
    if (i < bdlp_pkg::FIELD_WIDTH) begin : g_pin
      assign raw = pin_levels[i];
    end else begin : g_nopin
      assign raw = 1'b0;
    end

    bdlp_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .step   (step),
      .raw    (raw),
      .cfg    (cfg),
      .result (lane_res[i])
    );
  end

  bdlp_merge u_merge (
    .clk               (clk),
    .rst               (rst),
    .step              (step),
    .lane_res          (lane_res),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .press_events      (press_events),
    .long_press_events (long_press_events),
    .stable_levels     (stable_levels)
  );

  // every accepted tick yields a result in the next cycle
  a_step_fills_output: assert property (@(posedge clk) disable iff (rst)
    step |=> out_valid)
    else $error("accepted transaction produced no result");

  // no events may come out of a tick taken with scanning off
  a_no_events_when_idle: assert property (@(posedge clk) disable iff (rst)
    (step && !cfg.scan_enable) |=> (press_events == '0 && long_press_events == '0))
    else $error("event reported while scanning disabled");

  // a press event always comes with the button reported as pressed
  a_press_means_low: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((press_events & stable_levels) == '0))
    else $error("press event on a released button");

endmodule
